[rtl/hstcp_pkg.sv]
// ----------------------------------------------------------------------------
// hstcp_pkg
// Shared types, field widths, event codes and the AIMD table constants for the
// HighSpeed TCP window engine.
// ----------------------------------------------------------------------------
package hstcp_pkg;

    localparam int KIND_W  = 2;
    localparam int CWND_W  = 25;
    localparam int THR_W   = 31;
    localparam int ACK_W   = 16;
    localparam int IDX_W   = 7;
    localparam int MD_W    = 8;
    localparam int BOUND_W = 17;

    localparam int ROM_ENTRIES   = 74;
    localparam int TABLE_ENTRIES = 74;
    localparam int USED_ENTRIES  = (TABLE_ENTRIES < ROM_ENTRIES) ? TABLE_ENTRIES : ROM_ENTRIES;
    localparam int LAST_ENTRY    = USED_ENTRIES - 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_ENTRY);

    // per-connection state store: a single index entry
    localparam int IDX_DEPTH = 1;

    localparam logic [CWND_W-1:0] CWND_MAX  = '1;
    localparam logic [CWND_W-1:0] CLAMP_RST = '1;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOSS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT = 2'd2;

    // upper window bound of each bracket
    localparam logic [BOUND_W-1:0] BOUND_ROM [0:ROM_ENTRIES-1] = '{
        17'd36,    17'd119,   17'd218,   17'd347,   17'd494,
        17'd495,   17'd496,   17'd663,   17'd851,   17'd1058,
        17'd1284,  17'd1529,  17'd1793,  17'd2076,  17'd2239,
        17'd2378,  17'd2699,  17'd3039,  17'd3399,  17'd3778,
        17'd4177,  17'd4596,  17'd5036,  17'd5497,  17'd5979,
        17'd6483,  17'd7009,  17'd7558,  17'd8130,  17'd8726,
        17'd9346,  17'd9991,  17'd10661, 17'd11358, 17'd12082,
        17'd12834, 17'd13614, 17'd14424, 17'd15265, 17'd17042,
        17'd17981, 17'd18955, 17'd19965, 17'd21013, 17'd22101,
        17'd23230, 17'd24402, 17'd25618, 17'd26881, 17'd28193,
        17'd29557, 17'd30975, 17'd32450, 17'd33986, 17'd35586,
        17'd37253, 17'd38992, 17'd40808, 17'd42707, 17'd44694,
        17'd46776, 17'd48961, 17'd53677, 17'd56230, 17'd58932,
        17'd61799, 17'd64851, 17'd68113, 17'd71617, 17'd73739,
        17'd75401, 17'd79517, 17'd84035, 17'd89053
    };

    // decrease factor, scaled by 256
    localparam logic [MD_W-1:0] MD_ROM [0:ROM_ENTRIES-1] = '{
        8'd128, 8'd115, 8'd107, 8'd101, 8'd99,  8'd97,  8'd96,  8'd89,
        8'd87,  8'd84,  8'd81,  8'd78,  8'd76,  8'd74,  8'd72,  8'd69,
        8'd68,  8'd67,  8'd66,  8'd65,  8'd64,  8'd63,  8'd62,  8'd61,
        8'd60,  8'd59,  8'd58,  8'd57,  8'd56,  8'd56,  8'd55,  8'd54,
        8'd54,  8'd53,  8'd52,  8'd52,  8'd51,  8'd50,  8'd50,  8'd49,
        8'd48,  8'd48,  8'd47,  8'd47,  8'd46,  8'd45,  8'd44,  8'd44,
        8'd43,  8'd42,  8'd41,  8'd41,  8'd40,  8'd39,  8'd38,  8'd38,
        8'd37,  8'd36,  8'd35,  8'd35,  8'd34,  8'd33,  8'd32,  8'd32,
        8'd31,  8'd30,  8'd29,  8'd29,  8'd28,  8'd27,  8'd26,  8'd26,
        8'd25,  8'd24
    };

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CWND_W-1:0] cwnd;
        logic [CWND_W-1:0] cwnd_count;
        logic [THR_W-1:0]  slow_start_threshold;
        logic [ACK_W-1:0]  acked_segments;
        logic              window_limited;
    } item_t;

    typedef struct packed {
        logic [CWND_W-1:0] new_cwnd;
        logic [CWND_W-1:0] new_cwnd_count;
        logic [THR_W-1:0]  new_threshold;
        logic [IDX_W-1:0]  table_index;
    } result_t;

endpackage

[rtl/hstcp_if.sv]
// ----------------------------------------------------------------------------
// hstcp_in_if / hstcp_out_if
// Valid/ready channels for event beats and result beats.
// ----------------------------------------------------------------------------
interface hstcp_in_if;
    logic                              valid;
    logic                              ready;
    logic [hstcp_pkg::KIND_W-1:0]      kind;
    logic [hstcp_pkg::CWND_W-1:0]      cwnd;
    logic [hstcp_pkg::CWND_W-1:0]      cwnd_count;
    logic [hstcp_pkg::THR_W-1:0]       slow_start_threshold;
    logic [hstcp_pkg::ACK_W-1:0]       acked_segments;
    logic                              window_limited;

    modport source (
        output valid, kind, cwnd, cwnd_count, slow_start_threshold,
               acked_segments, window_limited,
        input  ready
    );
    modport sink (
        input  valid, kind, cwnd, cwnd_count, slow_start_threshold,
               acked_segments, window_limited,
        output ready
    );
endinterface

interface hstcp_out_if;
    logic                              valid;
    logic                              ready;
    logic [hstcp_pkg::CWND_W-1:0]      new_cwnd;
    logic [hstcp_pkg::CWND_W-1:0]      new_cwnd_count;
    logic [hstcp_pkg::THR_W-1:0]       new_threshold;
    logic [hstcp_pkg::IDX_W-1:0]       table_index;

    modport source (
        output valid, new_cwnd, new_cwnd_count, new_threshold, table_index,
        input  ready
    );
    modport sink (
        input  valid, new_cwnd, new_cwnd_count, new_threshold, table_index,
        output ready
    );
endinterface

[rtl/hstcp_ram.sv]
// ----------------------------------------------------------------------------
// hstcp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hstcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hstcp_calc.sv]
// ----------------------------------------------------------------------------
// hstcp_calc
// Window update datapath: bracket search, slow start, additive increase and
// multiplicative decrease for one event.
// ----------------------------------------------------------------------------
module hstcp_calc (
    input  hstcp_pkg::item_t                 item,
    input  logic [hstcp_pkg::IDX_W-1:0]      cur_idx,
    input  logic [hstcp_pkg::CWND_W-1:0]     clamp,
    output hstcp_pkg::result_t               result
);

    localparam int CW = hstcp_pkg::CWND_W;
    localparam int TW = hstcp_pkg::THR_W;

    logic [hstcp_pkg::IDX_W-1:0]   srch_idx;
    logic [CW:0]                   ss_sum;
    logic [TW-1:0]                 ss_thr;
    logic [TW-1:0]                 ss_win;
    logic [CW:0]                   inc_sum;
    logic [CW:0]                   inc_left;
    logic [CW-1:0]                 inc_cwnd;
    logic [CW-1:0]                 inc_cnt;
    logic [CW+hstcp_pkg::MD_W-1:0] prod;
    logic [CW-1:0]                 dec;
    logic [CW-1:0]                 loss_t;
    logic [TW-1:0]                 loss_thr;

    // bounds ascend, so the first bound not below cwnd wins
    always_comb
    begin
        srch_idx = hstcp_pkg::LAST_IDX;
        for (int i = hstcp_pkg::LAST_ENTRY - 1; i >= 0; i--)
        begin
            if (item.cwnd <= CW'(hstcp_pkg::BOUND_ROM[i]))
            begin
                srch_idx = hstcp_pkg::IDX_W'(i);
            end
        end
    end

    // slow start
    always_comb
    begin
        ss_sum = {1'b0, item.cwnd} + (CW+1)'(item.acked_segments);
        ss_thr = (TW'(ss_sum) > item.slow_start_threshold) ?
                 item.slow_start_threshold : TW'(ss_sum);
        ss_win = (ss_thr > TW'(clamp)) ? TW'(clamp) : ss_thr;
    end

    // additive increase
    always_comb
    begin
        inc_sum  = {1'b0, item.cwnd_count} + (CW+1)'(srch_idx) + (CW+1)'(1);
        inc_cwnd = item.cwnd;
        inc_left = inc_sum;
        if (inc_sum >= {1'b0, item.cwnd})
        begin
            inc_left = inc_sum - {1'b0, item.cwnd};
            inc_cwnd = item.cwnd + CW'(1);
        end
        inc_cnt = inc_left[CW] ? hstcp_pkg::CWND_MAX : inc_left[CW-1:0];
    end

    // multiplicative decrease
    always_comb
    begin
        prod     = (CW+hstcp_pkg::MD_W)'(item.cwnd) *
                   (CW+hstcp_pkg::MD_W)'(hstcp_pkg::MD_ROM[cur_idx]);
        dec      = prod[CW+hstcp_pkg::MD_W-1:8];
        loss_t   = item.cwnd - dec;
        loss_thr = (loss_t < CW'(2)) ? TW'(2) : TW'(loss_t);
    end

    always_comb
    begin
        result.new_cwnd       = item.cwnd;
        result.new_cwnd_count = item.cwnd_count;
        result.new_threshold  = item.slow_start_threshold;
        result.table_index    = cur_idx;
        case (item.kind)
            hstcp_pkg::KIND_ACK:
            begin
                if (item.window_limited)
                begin
                    if (TW'(item.cwnd) <= item.slow_start_threshold)
                    begin
                        result.new_cwnd = ss_win[CW-1:0];
                    end
                    else
                    begin
                        result.table_index = srch_idx;
                        if (item.cwnd < clamp)
                        begin
                            result.new_cwnd       = inc_cwnd;
                            result.new_cwnd_count = inc_cnt;
                        end
                    end
                end
            end
            hstcp_pkg::KIND_LOSS:
            begin
                result.new_threshold = loss_thr;
            end
            hstcp_pkg::KIND_INIT:
            begin
                result.table_index = '0;
            end
            default:
            begin
                result.table_index = cur_idx;
            end
        endcase
    end

endmodule

[rtl/hstcp_window_update.sv]
// ----------------------------------------------------------------------------
// hstcp_window_update
// HighSpeed TCP window engine: AIMD index held in a one-entry RAM, table ROM
// in the package, one result beat per event beat.
// ----------------------------------------------------------------------------
// The index RAM is read on the accepting edge; compute, result register and
// index write-back follow in ST_EXEC, which stalls while an earlier result is
// not taken. No new event is accepted until ST_EXEC has retired, so each event
// finishes its read-modify-write of the index RAM before the next is read.
// Reset: rst_n clears the FSM, the output valid and the index valid flag
// (index reads as 0 until written); window_clamp resets to 33554431.
// ----------------------------------------------------------------------------
module hstcp_window_update (
    input  logic                           clk,
    input  logic                           rst_n,
    hstcp_in_if.sink                       req,
    hstcp_out_if.source                    rsp,
    input  logic                           cfg_we,
    input  logic [hstcp_pkg::CWND_W-1:0]   cfg_wdata
);

    localparam int AW = (hstcp_pkg::IDX_DEPTH > 1) ? $clog2(hstcp_pkg::IDX_DEPTH) : 1;

    hstcp_pkg::state_t             state_reg;
    hstcp_pkg::state_t             state_next;
    hstcp_pkg::item_t              item_reg;
    hstcp_pkg::result_t            result_reg;
    hstcp_pkg::result_t            calc_result;
    logic [hstcp_pkg::CWND_W-1:0]  clamp_reg;
    logic                          idx_valid_reg;
    logic                          out_valid_reg;
    logic [hstcp_pkg::IDX_W-1:0]   ram_rdata;
    logic [hstcp_pkg::IDX_W-1:0]   cur_idx;
    logic                          accept;
    logic                          exec_done;

    assign accept = req.valid && req.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hstcp_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = hstcp_pkg::ST_EXEC;
                end
            end
            hstcp_pkg::ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = hstcp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hstcp_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs; result slot must be free before the exec beat retires
    always_comb
    begin
        req.ready = 1'b0;
        exec_done = 1'b0;
        case (state_reg)
            hstcp_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            hstcp_pkg::ST_EXEC:
            begin
                exec_done = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hstcp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_valid_reg <= 1'b0;
            clamp_reg     <= hstcp_pkg::CLAMP_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_done)
            begin
                out_valid_reg <= 1'b1;
                idx_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                clamp_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind                 <= req.kind;
            item_reg.cwnd                 <= req.cwnd;
            item_reg.cwnd_count           <= req.cwnd_count;
            item_reg.slow_start_threshold <= req.slow_start_threshold;
            item_reg.acked_segments       <= req.acked_segments;
            item_reg.window_limited       <= req.window_limited;
        end
        if (exec_done)
        begin
            result_reg <= calc_result;
        end
    end

    // index store: read on accept, written back when the exec beat retires
    hstcp_ram #(
        .WIDTH (hstcp_pkg::IDX_W),
        .DEPTH (hstcp_pkg::IDX_DEPTH)
    ) u_idx_ram (
        .clk   (clk),
        .we    (exec_done),
        .waddr (AW'(0)),
        .wdata (calc_result.table_index),
        .re    (accept),
        .raddr (AW'(0)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_idx = idx_valid_reg ? ram_rdata : '0;
        if (cur_idx > hstcp_pkg::LAST_IDX)
        begin
            cur_idx = hstcp_pkg::LAST_IDX;
        end
    end

    hstcp_calc u_calc (
        .item   (item_reg),
        .cur_idx(cur_idx),
        .clamp  (clamp_reg),
        .result (calc_result)
    );

    assign rsp.valid          = out_valid_reg;
    assign rsp.new_cwnd       = result_reg.new_cwnd;
    assign rsp.new_cwnd_count = result_reg.new_cwnd_count;
    assign rsp.new_threshold  = result_reg.new_threshold;
    assign rsp.table_index    = result_reg.table_index;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == hstcp_pkg::ST_EXEC)
        else $error("accepted beat did not enter exec");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == hstcp_pkg::ST_EXEC))
        else $error("result valid without an exec beat");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.table_index <= hstcp_pkg::LAST_IDX)
        else $error("table index out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> $stable(result_reg))
        else $error("pending result overwritten");

endmodule

[verif/hstcp_window_update_checker.sv]
// ----------------------------------------------------------------------------
// hstcp_window_update_checker
// Watches the event and result channels of the HighSpeed TCP window engine,
// predicts each result beat from its own copy of the AIMD index and the
// window clamp, and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module hstcp_window_update_checker
    import hstcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    hstcp_in_if               req,
    hstcp_out_if              rsp,
    input  logic              cfg_we,
    input  logic [CWND_W-1:0] cfg_wdata,
    output int                errors,
    output int                pending,
    output int                n_window_steps,
    output int                n_losses
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned       LAST_BRACKET = 73;
    localparam longint unsigned   COUNT_SAT    = 64'd33554431;

    localparam int unsigned BRACKET_TOP [0:73] = '{
        36, 119, 218, 347, 494, 495, 496, 663, 851, 1058,
        1284, 1529, 1793, 2076, 2239, 2378, 2699, 3039, 3399, 3778,
        4177, 4596, 5036, 5497, 5979, 6483, 7009, 7558, 8130, 8726,
        9346, 9991, 10661, 11358, 12082, 12834, 13614, 14424, 15265, 17042,
        17981, 18955, 19965, 21013, 22101, 23230, 24402, 25618, 26881, 28193,
        29557, 30975, 32450, 33986, 35586, 37253, 38992, 40808, 42707, 44694,
        46776, 48961, 53677, 56230, 58932, 61799, 64851, 68113, 71617, 73739,
        75401, 79517, 84035, 89053
    };

    // multiplicative decrease, scaled by 256
    localparam int unsigned DECREASE_X256 [0:73] = '{
        128, 115, 107, 101, 99, 97, 96, 89, 87, 84,
        81, 78, 76, 74, 72, 69, 68, 67, 66, 65,
        64, 63, 62, 61, 60, 59, 58, 57, 56, 56,
        55, 54, 54, 53, 52, 52, 51, 50, 50, 49,
        48, 48, 47, 47, 46, 45, 44, 44, 43, 42,
        41, 41, 40, 39, 38, 38, 37, 36, 35, 35,
        34, 33, 32, 32, 31, 30, 29, 29, 28, 27,
        26, 26, 25, 24
    };

    logic [IDX_W-1:0]  aimd_idx;
    logic [CWND_W-1:0] clamp;
    result_t           window_q [$];

    function automatic result_t predict_window(input item_t ev);
        result_t         r;
        longint unsigned w;
        longint unsigned cnt;
        longint unsigned thr;
        longint unsigned sum;
        int unsigned     idx;
        int unsigned     i;
        w   = ev.cwnd;
        cnt = ev.cwnd_count;
        thr = ev.slow_start_threshold;
        idx = (aimd_idx > LAST_BRACKET) ? LAST_BRACKET : aimd_idx;
        if (ev.kind == KIND_ACK && ev.window_limited) begin
            if (w <= thr) begin
                // slow start
                sum = w + ev.acked_segments;
                if (sum > thr)
                    sum = thr;
                if (sum > clamp)
                    sum = clamp;
                w = sum;
            end
            else begin
                i = 0;
                while (i < LAST_BRACKET && w > BRACKET_TOP[i])
                    i++;
                idx      = i;
                aimd_idx = IDX_W'(i);
                if (w < clamp) begin
                    cnt += idx + 1;
                    if (cnt >= w) begin
                        cnt -= w;
                        w++;
                        n_window_steps++;
                    end
                    if (cnt > COUNT_SAT)
                        cnt = COUNT_SAT;
                end
            end
        end
        else if (ev.kind == KIND_LOSS) begin
            sum = (w * DECREASE_X256[idx]) >> 8;
            thr = (w - sum < 2) ? 2 : w - sum;
            n_losses++;
        end
        else if (ev.kind == KIND_INIT) begin
            aimd_idx = '0;
            idx      = 0;
        end
        r.new_cwnd       = CWND_W'(w);
        r.new_cwnd_count = CWND_W'(cnt);
        r.new_threshold  = THR_W'(thr);
        r.table_index    = IDX_W'(idx);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        item_t   ev;
        if (!rst_n) begin
            aimd_idx = '0;
            clamp    = CLAMP_RST;
            window_q.delete();
            errors         = 0;
            pending        = 0;
            n_window_steps = 0;
            n_losses       = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                got.new_cwnd       = rsp.new_cwnd;
                got.new_cwnd_count = rsp.new_cwnd_count;
                got.new_threshold  = rsp.new_threshold;
                got.table_index    = rsp.table_index;
                if (window_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] result beat with nothing expected: cwnd=%0d cnt=%0d thr=%0d idx=%0d",
                                 $time, got.new_cwnd, got.new_cwnd_count,
                                 got.new_threshold, got.table_index);
                end
                else begin
                    want = window_q.pop_front();
                    if (got.new_cwnd !== want.new_cwnd
                        || got.new_cwnd_count !== want.new_cwnd_count
                        || got.new_threshold !== want.new_threshold
                        || got.table_index !== want.table_index) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("[%0t] mismatch exp: cwnd=%0d cnt=%0d thr=%0d idx=%0d",
                                     $time, want.new_cwnd, want.new_cwnd_count,
                                     want.new_threshold, want.table_index);
                            $display("[%0t]          got: cwnd=%0d cnt=%0d thr=%0d idx=%0d",
                                     $time, got.new_cwnd, got.new_cwnd_count,
                                     got.new_threshold, got.table_index);
                        end
                    end
                end
            end
            if (cfg_we)
                clamp = cfg_wdata;
            if (req.valid && req.ready) begin
                ev.kind                 = req.kind;
                ev.cwnd                 = req.cwnd;
                ev.cwnd_count           = req.cwnd_count;
                ev.slow_start_threshold = req.slow_start_threshold;
                ev.acked_segments       = req.acked_segments;
                ev.window_limited       = req.window_limited;
                window_q.push_back(predict_window(ev));
            end
            pending = window_q.size();
        end
    end

endmodule

[verif/hstcp_window_update_tb.sv]
// ----------------------------------------------------------------------------
// hstcp_window_update_tb
// Drives event beats into the window engine through a short directed set and
// then random phases at several clamp settings and handshake modes; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module hstcp_window_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hstcp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;
    localparam logic [CWND_W-1:0] CWND_ONES      = '1;
    localparam logic [THR_W-1:0]  THR_ONES       = '1;
    localparam int                HOLD_CYCLES    = 80;
    localparam int                DRAIN_CYCLES   = 20;
    localparam int                WATCHDOG_LIMIT = 2000;

    localparam int unsigned EDGE_WINDOWS [0:15] = '{
        0, 1, 2, 3, 36, 37, 118, 119, 120, 494, 495, 496, 497, 89052, 89053, 89054
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CWND_W-1:0] cfg_wdata;

    int                n_errors;
    int                n_pending;
    int                n_window_steps;
    int                n_losses;
    int                n_sent;
    int                n_settings;
    int                send_idle_pct;
    int                stall_pct;
    int                hold_req;
    int                hold_seen;
    int                hold_left;
    logic [CWND_W-1:0] cur_clamp;

    hstcp_in_if  req_if ();
    hstcp_out_if rsp_if ();

    hstcp_window_update u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hstcp_window_update_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_if),
        .rsp            (rsp_if),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .errors         (n_errors),
        .pending        (n_pending),
        .n_window_steps (n_window_steps),
        .n_losses       (n_losses)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
        end
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic item_t mk(input logic [KIND_W-1:0] kind, input logic [CWND_W-1:0] cwnd,
                                 input logic [CWND_W-1:0] cnt, input logic [THR_W-1:0] thr,
                                 input logic [ACK_W-1:0] acked, input logic limited);
        item_t ev;
        ev.kind                 = kind;
        ev.cwnd                 = cwnd;
        ev.cwnd_count           = cnt;
        ev.slow_start_threshold = thr;
        ev.acked_segments       = acked;
        ev.window_limited       = limited;
        return ev;
    endfunction

    function automatic item_t random_event();
        item_t       ev;
        int unsigned pick;
        int unsigned w;
        int unsigned off;
        pick = $urandom_range(0, 99);
        ev.kind = (pick < 64) ? KIND_ACK : (pick < 84) ? KIND_LOSS :
                  (pick < 95) ? KIND_INIT : KIND_UNUSED;

        // mostly inside the AIMD table range, with bracket edges and clamp edges
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w = $urandom_range(0, 100000);
        else if (pick < 55)
            w = EDGE_WINDOWS[$urandom_range(0, 15)];
        else if (pick < 65)
            w = $urandom_range(0, 40);
        else if (pick < 75)
            w = cur_clamp + 1 - $urandom_range(0, 2);
        else if (pick < 90)
            w = $urandom;
        else
            w = CWND_ONES - $urandom_range(0, 100);
        ev.cwnd = CWND_W'(w);
        w = ev.cwnd;

        // counter close to the window so that it wraps often
        pick = $urandom_range(0, 99);
        off  = $urandom_range(0, 80);
        if (pick < 40)
            ev.cwnd_count = (w > off) ? CWND_W'(w - off) : '0;
        else if (pick < 60)
            ev.cwnd_count = CWND_W'($urandom_range(0, w));
        else if (pick < 80)
            ev.cwnd_count = CWND_W'($urandom);
        else
            ev.cwnd_count = CWND_ONES - CWND_W'($urandom_range(0, 3));

        pick = $urandom_range(0, 99);
        if (pick < 40)
            ev.slow_start_threshold = (w == 0) ? '0 : THR_W'($urandom_range(0, w - 1));
        else if (pick < 70)
            ev.slow_start_threshold = THR_W'(w + $urandom_range(0, 70000));
        else if (pick < 80)
            ev.slow_start_threshold = THR_W'(w);
        else if (pick < 95)
            ev.slow_start_threshold = THR_W'($urandom);
        else
            ev.slow_start_threshold = THR_ONES - THR_W'($urandom_range(0, 3));

        ev.acked_segments = ($urandom_range(0, 1) == 0) ? ACK_W'($urandom)
                                                        : ACK_W'($urandom_range(0, 64));
        ev.window_limited = ($urandom_range(0, 99) < 85);
        return ev;
    endfunction

    task automatic send_event(input item_t ev);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid                <= 1'b1;
        req_if.kind                 <= ev.kind;
        req_if.cwnd                 <= ev.cwnd;
        req_if.cwnd_count           <= ev.cwnd_count;
        req_if.slow_start_threshold <= ev.slow_start_threshold;
        req_if.acked_segments       <= ev.acked_segments;
        req_if.window_limited       <= ev.window_limited;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        n_sent++;
    endtask

    // one idle edge first so that the last accepted beat is already counted
    task automatic wait_drained();
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
    endtask

    task automatic set_clamp(input logic [CWND_W-1:0] clamp);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= clamp;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_clamp  = clamp;
        n_settings++;
    endtask

    // hold_at: beat at which the result side holds off; drain_at: beat at
    // which the sender pauses until every result is back
    task automatic run_phase(input logic [CWND_W-1:0] clamp, input int idle_pct,
                             input int stall_in, input int n, input int hold_at,
                             input int drain_at);
        set_clamp(clamp);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        for (int k = 0; k < n; k++)
        begin
            if (k == hold_at)
                hold_req++;
            if (k == drain_at)
            begin
                req_if.valid <= 1'b0;
                wait_drained();
            end
            send_event(random_event());
        end
        req_if.valid <= 1'b0;
    endtask

    initial
    begin
        item_t directed [$];
        rst_n                       = 1'b0;
        cfg_we                      = 1'b0;
        cfg_wdata                   = '0;
        req_if.valid                = 1'b0;
        req_if.kind                 = KIND_ACK;
        req_if.cwnd                 = '0;
        req_if.cwnd_count           = '0;
        req_if.slow_start_threshold = '0;
        req_if.acked_segments       = '0;
        req_if.window_limited       = 1'b0;
        rsp_if.ready                = 1'b0;
        send_idle_pct               = 0;
        stall_pct                   = 0;
        hold_req                    = 0;
        hold_seen                   = 0;
        hold_left                   = 0;
        n_sent                      = 0;
        n_settings                  = 0;
        cur_clamp                   = CLAMP_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: slow start caps, bracket edges, counter wrap, loss floor
        directed.push_back(mk(KIND_INIT, 0, 0, 0, 0, 1'b0));
        directed.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1'b1));
        directed.push_back(mk(KIND_ACK, 10, 5, 100, 16'hffff, 1'b1));
        directed.push_back(mk(KIND_ACK, CWND_ONES, 0, THR_ONES, 16'hffff, 1'b1));
        directed.push_back(mk(KIND_ACK, 12345, 77, 10, 500, 1'b0));
        directed.push_back(mk(KIND_ACK, 36, 0, 0, 0, 1'b1));
        directed.push_back(mk(KIND_ACK, 37, 35, 10, 0, 1'b1));
        directed.push_back(mk(KIND_LOSS, 37, 0, 999, 0, 1'b0));
        directed.push_back(mk(KIND_ACK, 495, 490, 100, 0, 1'b1));
        directed.push_back(mk(KIND_LOSS, 495, 1, 2, 3, 1'b1));
        directed.push_back(mk(KIND_ACK, 89053, 0, 0, 0, 1'b1));
        directed.push_back(mk(KIND_ACK, 89054, 89000, 0, 0, 1'b1));
        directed.push_back(mk(KIND_ACK, CWND_ONES, 5, 0, 0, 1'b1));
        directed.push_back(mk(KIND_LOSS, CWND_ONES, 0, 0, 0, 1'b1));
        directed.push_back(mk(KIND_ACK, 1, CWND_ONES, 0, 0, 1'b1));
        directed.push_back(mk(KIND_LOSS, 0, 0, THR_ONES, 0, 1'b0));
        directed.push_back(mk(KIND_LOSS, 3, 0, 0, 0, 1'b0));
        directed.push_back(mk(KIND_INIT, 500, 3, 4, 5, 1'b1));
        directed.push_back(mk(KIND_LOSS, 100, 0, 0, 0, 1'b0));
        directed.push_back(mk(KIND_UNUSED, 777, 888, 999, 1000, 1'b1));
        directed.push_back(mk(KIND_UNUSED, CWND_ONES, CWND_ONES, THR_ONES, 16'hffff, 1'b1));
        directed.push_back(mk(KIND_ACK, 100, 0, 100, 0, 1'b1));
        directed.push_back(mk(KIND_ACK, 101, 100, 100, 0, 1'b1));

        set_clamp(CLAMP_RST);
        foreach (directed[i])
            send_event(directed[i]);
        req_if.valid <= 1'b0;

        run_phase(CLAMP_RST, 0, 0, 250, -1, -1);
        run_phase(25'd2, 58, 0, 200, -1, -1);
        run_phase(25'd40, 0, 58, 200, 50, -1);
        run_phase(25'd500, 11, 11, 200, -1, -1);
        run_phase(25'd100000, 0, 0, 250, -1, 100);
        run_phase(CWND_W'($urandom_range(2, 33554431)), 58, 0, 250, -1, -1);
        run_phase(25'd89053, 0, 58, 200, 120, -1);
        run_phase(CLAMP_RST, 11, 11, 200, -1, -1);
        run_phase(25'd3, 0, 0, 200, -1, -1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d event beats over %0d clamp settings, four handshake modes",
                 n_sent, n_settings);
        $display("covered %0d additive window steps and %0d loss decreases",
                 n_window_steps, n_losses);
        if (n_errors == 0 && n_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
